### hw/rtl/shell_command_tokenizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Shell command tokenizer assertion macros
// Immediate-style wrappers for concurrent checks, clocked on aclk and
// disabled while aresetn is low. Compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_TOKENIZER_UNIT_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCT_ASSERT_IMP(lbl, ante, cons, msg)
`define SCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Types, character codes and classification helpers shared by the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    localparam int MAX_RES = 3;

    localparam logic [1:0] CLS_WORD = 2'd0;
    localparam logic [1:0] CLS_SQ   = 2'd1;
    localparam logic [1:0] CLS_DQ   = 2'd2;
    localparam logic [1:0] CLS_OP   = 2'd3;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_class;
        logic       line_done;
    } res_t;

    typedef struct packed {
        logic                      load;
        logic [1:0]                count;
        res_t [MAX_RES-1:0]        item;
    } step_t;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_pairable(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return is_pairable(c) || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

    function automatic res_t mk_res(input logic [7:0] ch, input logic valid,
                                    input logic start, input logic fin,
                                    input logic [1:0] cls, input logic done);
        res_t r;
        r.char_out    = ch;
        r.char_valid  = valid;
        r.token_start = start;
        r.token_end   = fin;
        r.token_class = cls;
        r.line_done   = done;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/shell_command_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// shell_command_tokenizer_unit
// Streams a command line in one byte per beat and streams token characters
// out with start/end flags, class and a line-done marker.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one command-line byte per beat in s_tdata; s_tlast (or a
//   zero byte) ends the line. m_ channel: one result per beat; m_tlast marks
//   the last beat caused by an input byte. A byte may cause zero to three
//   beats (held char, closing quote or operator pair, line-done marker).
//   An accepted byte waits in the input register for the result register to
//   be free, and its beats are then registered there. Throughput: one byte
//   per cycle while each byte yields at most one beat and m_tready is high;
//   more beats hold that register while the single output port drains one per cycle.
//   Reset: synchronous on aresetn low; lexer returns to between-tokens with
//   nothing held, all pending beats are dropped.
//   Stall: when m_tready is low the result register holds its beats; the
//   input register then fills and s_tready drops until the last beat of the
//   current step is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_tokenizer_unit
    import sct_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_byte
    input  wire logic       s_tlast,   // end_of_line
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_out
    output logic [5:0]      m_tuser,   // [0] char_valid [1] token_start [2] token_end
                                       // [4:3] token_class [5] line_done
    output logic            m_tlast    // run_last
);

    step_t step;
    logic  buf_free;

    sct_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .buf_free (buf_free),
        .step     (step)
    );

    sct_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/sct_core.sv
// ----------------------------------------------------------------------------
// sct_core
// Input register, lexer state and the single-pass step that turns one byte
// into up to three result beats.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shell_command_tokenizer_unit_defines.svh"

module sct_core
    import sct_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       buf_free,
    output step_t           step
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_SQ   = 3'd2,
        MODE_DQ   = 3'd3,
        MODE_OP   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       first;
        logic [1:0] cls;
        mode_t      mode;
    } hold_t;

    localparam hold_t IDLE_HOLD = '{ch: CH_NUL, valid: 1'b0, first: 1'b0,
                                    cls: CLS_WORD, mode: MODE_IDLE};

    function automatic hold_t start_token(input logic [7:0] c);
        hold_t h;
        h = '{ch: c, valid: 1'b1, first: 1'b1, cls: CLS_WORD, mode: MODE_WORD};
        if (is_space(c)) begin
            h = IDLE_HOLD;
        end else if (c == CH_SQUOTE) begin
            h.cls  = CLS_SQ;
            h.mode = MODE_SQ;
        end else if (c == CH_DQUOTE) begin
            h.cls  = CLS_DQ;
            h.mode = MODE_DQ;
        end else if (is_oper(c)) begin
            h.cls  = CLS_OP;
            h.mode = MODE_OP;
        end
        return h;
    endfunction

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eol_reg;

    mode_t       mode_reg;
    logic [7:0]  held_char_reg;
    logic        held_valid_reg;
    logic        held_first_reg;
    logic [1:0]  held_class_reg;

    hold_t       hold_next;
    logic        in_valid_next;
    logic        fire;
    logic        line_end;
    logic [1:0]  n;
    res_t [MAX_RES-1:0] res_arr;
    res_t        held_res;
    logic [7:0]  quote_ch;
    logic [1:0]  quote_cls;

    assign fire     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;
    assign line_end = in_eol_reg || (in_char_reg == CH_NUL);

    always_comb begin
        res_arr   = '0;
        n         = 2'd0;
        hold_next = IDLE_HOLD;
        held_res  = mk_res(held_char_reg, 1'b1, held_first_reg, 1'b0,
                           held_class_reg, 1'b0);
        quote_ch  = (mode_reg == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
        quote_cls = (mode_reg == MODE_SQ) ? CLS_SQ : CLS_DQ;

        if (line_end) begin
            unique case (mode_reg)
                MODE_SQ, MODE_DQ: begin
                    if (held_valid_reg) begin
                        res_arr[n] = held_res;
                        n = n + 2'd1;
                    end
                    res_arr[n] = mk_res(quote_ch, 1'b1, 1'b0, 1'b1, quote_cls, 1'b0);
                    n = n + 2'd1;
                end
                MODE_WORD, MODE_OP: begin
                    if (held_valid_reg) begin
                        res_arr[n] = held_res;
                        res_arr[n].token_end = 1'b1;
                        n = n + 2'd1;
                    end
                end
                default: begin
                end
            endcase
            res_arr[n] = mk_res(CH_NUL, 1'b0, 1'b0, 1'b0, CLS_WORD, 1'b1);
            n = n + 2'd1;
        end else begin
            unique case (mode_reg)
                MODE_SQ, MODE_DQ: begin
                    if (held_valid_reg) begin
                        res_arr[n] = held_res;
                        n = n + 2'd1;
                    end
                    if (in_char_reg == quote_ch) begin
                        res_arr[n] = mk_res(in_char_reg, 1'b1, 1'b0, 1'b1,
                                            quote_cls, 1'b0);
                        n = n + 2'd1;
                    end else begin
                        hold_next = '{ch: in_char_reg, valid: 1'b1, first: 1'b0,
                                      cls: quote_cls, mode: mode_reg};
                    end
                end
                MODE_WORD: begin
                    if (held_valid_reg) begin
                        res_arr[n] = held_res;
                        n = n + 2'd1;
                    end
                    if (is_space(in_char_reg) || is_oper(in_char_reg) ||
                        (in_char_reg == CH_SQUOTE) || (in_char_reg == CH_DQUOTE)) begin
                        res_arr[0].token_end = 1'b1;
                        hold_next = start_token(in_char_reg);
                    end else begin
                        hold_next = '{ch: in_char_reg, valid: 1'b1, first: 1'b0,
                                      cls: CLS_WORD, mode: MODE_WORD};
                    end
                end
                MODE_OP: begin
                    if (held_valid_reg && is_pairable(held_char_reg) &&
                        (in_char_reg == held_char_reg)) begin
                        res_arr[0] = mk_res(held_char_reg, 1'b1, 1'b1, 1'b0,
                                            CLS_OP, 1'b0);
                        res_arr[1] = mk_res(in_char_reg, 1'b1, 1'b0, 1'b1,
                                            CLS_OP, 1'b0);
                        n = 2'd2;
                    end else begin
                        if (held_valid_reg) begin
                            res_arr[n] = held_res;
                            res_arr[n].token_end = 1'b1;
                            n = n + 2'd1;
                        end
                        hold_next = start_token(in_char_reg);
                    end
                end
                default: begin
                    hold_next = start_token(in_char_reg);
                end
            endcase
        end
    end

    assign step.load  = fire;
    assign step.count = n;
    assign step.item  = res_arr;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= MODE_IDLE;
            held_char_reg  <= CH_NUL;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            held_class_reg <= CLS_WORD;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                mode_reg       <= hold_next.mode;
                held_char_reg  <= hold_next.ch;
                held_valid_reg <= hold_next.valid;
                held_first_reg <= hold_next.first;
                held_class_reg <= hold_next.cls;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    `SCT_ASSERT_NXT(a_eol_clears, fire && line_end, (mode_reg == MODE_IDLE) && !held_valid_reg, "line end left a token open")
    `SCT_ASSERT_IMP(a_eol_emits, fire && line_end, n != 2'd0, "line end produced no beats")
    `SCT_ASSERT_IMP(a_held_mode, held_valid_reg, mode_reg != MODE_IDLE, "held char while idle")

endmodule

`default_nettype wire

### hw/rtl/sct_out_buf.sv
// ----------------------------------------------------------------------------
// sct_out_buf
// Result register: holds one step's beats; drains one per cycle if m_tready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shell_command_tokenizer_unit_defines.svh"

module sct_out_buf
    import sct_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire step_t      step,
    output logic            buf_free,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [5:0]      m_tuser,
    output logic            m_tlast
);

    res_t [MAX_RES-1:0] item_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         idx_reg;
    logic [1:0]         cnt_next;
    logic [1:0]         idx_next;
    res_t               cur;

    assign cur      = item_reg[idx_reg];
    assign m_tvalid = idx_reg < cnt_reg;
    assign m_tlast  = (idx_reg + 2'd1) == cnt_reg;
    assign buf_free = !m_tvalid || (m_tready && m_tlast);
    assign m_tdata  = cur.char_out;
    assign m_tuser  = {cur.line_done, cur.token_class, cur.token_end,
                       cur.token_start, cur.char_valid};

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (step.load) begin
            cnt_next = step.count;
            idx_next = 2'd0;
        end else if (m_tvalid && m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.load) begin
            item_reg <= step.item;
        end
    end

    `SCT_ASSERT_IMP(a_load_free, step.load, buf_free, "step loaded over pending beats")
    `SCT_ASSERT_IMP(a_idx_range, 1'b1, idx_reg <= cnt_reg, "drain index past count")
    `SCT_ASSERT_IMP(a_done_last, m_tvalid && cur.line_done, m_tlast, "line marker not last")

endmodule

`default_nettype wire

### tb/sv/shell_command_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Shell command tokenizer testbench
// Drives command-line bytes into the s_ channel and checks every m_ beat
// against a cycle-free lexer model kept in the bench. Directed lines cover
// blanks, high bytes, operator pairing and quoted or unclosed tokens; random
// lines of words, quotes, operators and noise then run under four mixes of
// source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_unit_tb;
    import sct_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_WORD = 3'd1,
        LX_SQ   = 3'd2,
        LX_DQ   = 3'd3,
        LX_OP   = 3'd4
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_class;
        logic       line_done;
        logic       run_last;
    } tok_beat_t;

    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;
    logic       m_tlast;

    // lexer model state
    lex_mode_t  tok_mode   = LX_IDLE;
    logic [7:0] hold_ch    = 8'h00;
    logic       hold_v     = 1'b0;
    logic       hold_first = 1'b0;
    logic [1:0] hold_cls   = CLS_WORD;

    tok_beat_t  pending_beats[$];
    tok_beat_t  step_beats[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int live_bytes     = 0;
    int lines_sent     = 0;
    int beats_checked  = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    shell_command_tokenizer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_pair_char(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return is_pair_char(c) || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

    function automatic void push_beat(input logic [7:0] ch, input logic valid,
                                      input logic start, input logic fin,
                                      input logic [1:0] cls, input logic done);
        tok_beat_t b;
        b.char_out    = ch;
        b.char_valid  = valid;
        b.token_start = start;
        b.token_end   = fin;
        b.token_class = cls;
        b.line_done   = done;
        b.run_last    = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void hold_char(input logic [7:0] c, input logic first,
                                      input logic [1:0] cls, input lex_mode_t md);
        hold_ch    = c;
        hold_v     = 1'b1;
        hold_first = first;
        hold_cls   = cls;
        tok_mode   = md;
    endfunction

    function automatic void clear_hold();
        hold_ch    = 8'h00;
        hold_v     = 1'b0;
        hold_first = 1'b0;
        hold_cls   = CLS_WORD;
        tok_mode   = LX_IDLE;
    endfunction

    function automatic void flush_held(input logic fin);
        if (hold_v)
            push_beat(hold_ch, 1'b1, hold_first, fin, hold_cls, 1'b0);
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (is_blank(c))
            clear_hold();
        else if (c == CH_SQUOTE)
            hold_char(c, 1'b1, CLS_SQ, LX_SQ);
        else if (c == CH_DQUOTE)
            hold_char(c, 1'b1, CLS_DQ, LX_DQ);
        else if (is_op_char(c))
            hold_char(c, 1'b1, CLS_OP, LX_OP);
        else
            hold_char(c, 1'b1, CLS_WORD, LX_WORD);
    endfunction

    // advance the lexer by one byte and queue the beats it yields
    function automatic void lex_byte(input logic [7:0] c, input logic eol);
        logic [7:0] q;
        logic [1:0] qcls;
        tok_beat_t  b;
        step_beats.delete();
        q    = (tok_mode == LX_SQ) ? CH_SQUOTE : CH_DQUOTE;
        qcls = (tok_mode == LX_SQ) ? CLS_SQ : CLS_DQ;
        if (eol || (c != CH_NUL) && !(tok_mode == LX_IDLE && is_blank(c)))
            live_bytes++;
        else if (c == CH_NUL)
            live_bytes++;
        if (eol || (c == CH_NUL)) begin
            if ((tok_mode == LX_SQ) || (tok_mode == LX_DQ)) begin
                flush_held(1'b0);
                push_beat(q, 1'b1, 1'b0, 1'b1, qcls, 1'b0);
            end else if (tok_mode != LX_IDLE) begin
                flush_held(1'b1);
            end
            push_beat(CH_NUL, 1'b0, 1'b0, 1'b0, CLS_WORD, 1'b1);
            clear_hold();
        end else begin
            case (tok_mode)
                LX_SQ, LX_DQ: begin
                    flush_held(1'b0);
                    if (c == q) begin
                        push_beat(c, 1'b1, 1'b0, 1'b1, qcls, 1'b0);
                        clear_hold();
                    end else begin
                        hold_char(c, 1'b0, qcls, tok_mode);
                    end
                end
                LX_WORD: begin
                    if (is_blank(c) || is_op_char(c) || (c == CH_SQUOTE) ||
                        (c == CH_DQUOTE)) begin
                        flush_held(1'b1);
                        open_token(c);
                    end else begin
                        flush_held(1'b0);
                        hold_char(c, 1'b0, CLS_WORD, LX_WORD);
                    end
                end
                LX_OP: begin
                    if (hold_v && is_pair_char(hold_ch) && (c == hold_ch)) begin
                        push_beat(hold_ch, 1'b1, 1'b1, 1'b0, CLS_OP, 1'b0);
                        push_beat(c, 1'b1, 1'b0, 1'b1, CLS_OP, 1'b0);
                        clear_hold();
                    end else begin
                        flush_held(1'b1);
                        open_token(c);
                    end
                end
                default: open_token(c);
            endcase
        end
        if (step_beats.size() > 0) begin
            b = step_beats.pop_back();
            b.run_last = 1'b1;
            step_beats.push_back(b);
        end
        foreach (step_beats[i])
            pending_beats.push_back(step_beats[i]);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eol);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        lex_byte(c, eol);
    endtask

    task automatic stop_source();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic report_mismatch(input string what, input tok_beat_t want,
                                   input tok_beat_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s: expected ch=%h v=%b s=%b e=%b cls=%0d done=%b last=%b",
                     what, want.char_out, want.char_valid, want.token_start,
                     want.token_end, want.token_class, want.line_done, want.run_last);
            $display("    got ch=%h v=%b s=%b e=%b cls=%0d done=%b last=%b",
                     got.char_out, got.char_valid, got.token_start, got.token_end,
                     got.token_class, got.line_done, got.run_last);
        end
    endtask

    always @(posedge aclk) begin : beat_check
        tok_beat_t got;
        tok_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.char_out    = m_tdata;
            got.char_valid  = m_tuser[0];
            got.token_start = m_tuser[1];
            got.token_end   = m_tuser[2];
            got.token_class = m_tuser[4:3];
            got.line_done   = m_tuser[5];
            got.run_last    = m_tlast;
            beats_checked++;
            if (pending_beats.size() == 0) begin
                report_mismatch("beat with nothing pending", '0, got);
            end else begin
                want = pending_beats.pop_front();
                if ((got.char_out !== want.char_out) ||
                    (got.char_valid !== want.char_valid) ||
                    (got.token_start !== want.token_start) ||
                    (got.token_end !== want.token_end) ||
                    (got.token_class !== want.token_class) ||
                    (got.line_done !== want.line_done) ||
                    (got.run_last !== want.run_last))
                    report_mismatch("beat mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout after %0d cycles without a beat", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_blank(c) || is_op_char(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE));
        return c;
    endfunction

    function automatic logic [7:0] quoted_byte(input logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == q);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    function automatic logic [7:0] op_byte();
        case ($urandom_range(0, 5))
            0:       return CH_AMP;
            1:       return CH_PIPE;
            2:       return CH_LPAREN;
            3:       return CH_RPAREN;
            4:       return CH_LT;
            default: return CH_GT;
        endcase
    endfunction

    task automatic send_line();
        int         n_tok;
        logic [7:0] q;
        logic [7:0] c;
        logic       unclosed;
        n_tok    = $urandom_range(1, 6);
        unclosed = 1'b0;
        if ($urandom_range(0, 3) == 0)
            send_byte(blank_byte(), 1'b0);
        for (int t = 0; (t < n_tok) && !unclosed; t++) begin
            if (t > 0)
                repeat ($urandom_range(0, 2)) send_byte(blank_byte(), 1'b0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 5)) send_byte(word_byte(), 1'b0);
                end
                4, 5: begin
                    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                    send_byte(q, 1'b0);
                    repeat ($urandom_range(0, 4)) send_byte(quoted_byte(q), 1'b0);
                    if ($urandom_range(0, 7) == 0)
                        unclosed = 1'b1;
                    else
                        send_byte(q, 1'b0);
                end
                6: send_byte(op_byte(), 1'b0);
                7: begin
                    c = op_byte();
                    send_byte(c, 1'b0);
                    send_byte(c, 1'b0);
                end
                8: begin
                    send_byte(op_byte(), 1'b0);
                    send_byte(op_byte(), 1'b0);
                end
                default: send_byte(8'($urandom_range(0, 255)),
                                   ($urandom_range(0, 15) == 0));
            endcase
        end
        if ($urandom_range(0, 1))
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        else
            send_byte(CH_NUL, 1'b0);
        lines_sent++;
    endtask

    task automatic test_words_and_blanks();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_byte("w", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte("q", 1'b1);
        lines_sent++;
    endtask

    task automatic test_operator_pairs();
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_PIPE, 1'b0);
        send_byte(CH_PIPE, 1'b0);
        send_byte(CH_LPAREN, 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_NUL, 1'b0);
        lines_sent++;
    endtask

    task automatic test_quoted_tokens();
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte("a", 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("b", 1'b0);
        send_byte(8'hA5, 1'b1);
        lines_sent++;
    endtask

    task automatic test_random_lines(input int n_live, input int idle_pct,
                                     input int stall_pct);
        int goal;
        goal           = live_bytes + n_live;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (live_bytes < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end else begin
                send_line();
            end
        end
    endtask

    initial begin
        clear_hold();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_words_and_blanks();
        test_operator_pairs();
        test_quoted_tokens();
        test_random_lines(95, 0, 0);
        test_random_lines(95, 64, 0);
        test_random_lines(95, 0, 64);
        test_random_lines(95, 33, 33);
        stop_source();

        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes (%0d not ignored) in %0d command lines; checked %0d beats",
                 bytes_sent, live_bytes, lines_sent, beats_checked);
        $display("Covered blanks, high bytes, operator pairs, quoted and unclosed tokens, %s",
                 "line ends by flag and by zero byte, under four gap and stall mixes");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
